### hw/rtl/qsld_pkg.sv
// shared types, constants and helpers for the qam soft llr demapper
package qsld_pkg;

    // sample, scale and llr formats
    localparam int SAMPLE_W  = 16;
    localparam int SCALE_W   = 16;
    localparam int LLR_W     = 16;
    localparam int COUNT_W   = 4;
    localparam int NUM_LANES = 8;

    // fold operand: sample plus sign growth plus one bit of headroom
    localparam int OPW = SAMPLE_W + 2;
    // scale product: operand times zero-extended scale
    localparam int PW  = OPW + SCALE_W + 1;
    // second factor: 1/sqrt2 in q16 or unity (2^16)
    localparam int FW  = 18;
    // lanes 0 and 1 after the second factor
    localparam int QW  = PW + FW;

    // rounding shifts: fold lanes and the lanes carrying the second factor
    localparam int SHIFT_LO = SAMPLE_W + 1;
    localparam int SHIFT_HI = SAMPLE_W + 17;

    // cycles from an accepted word to its done strobe
    localparam int LATENCY = 5;

    // modulation codes of the configuration register
    typedef enum logic [2:0] {
        MOD_BPSK   = 3'd0,
        MOD_QPSK   = 3'd1,
        MOD_QAM16  = 3'd2,
        MOD_QAM64  = 3'd3,
        MOD_QAM256 = 3'd4
    } mod_t;

    typedef logic signed [OPW-1:0] opnd_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [QW-1:0]  wide_t;
    typedef logic signed [FW-1:0]  factor_t;
    typedef logic signed [LLR_W-1:0] llr_t;

    // decision thresholds in sample units (q2.13), rounded half up
    localparam opnd_t TH_16     = opnd_t'(5181);
    localparam opnd_t TH64_HI   = opnd_t'(5056);
    localparam opnd_t TH64_LO   = opnd_t'(2528);
    localparam opnd_t TH256_HI  = opnd_t'(4230);
    localparam opnd_t TH256_MID = opnd_t'(2115);
    localparam opnd_t TH256_LO  = opnd_t'(1058);

    // second factor for lanes 0 and 1
    localparam factor_t INV_SQRT2_Q16 = factor_t'(46341);
    localparam factor_t UNITY_Q16     = factor_t'(65536);

    // lane counts per modulation
    localparam logic [COUNT_W-1:0] CNT_BPSK   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] CNT_QPSK   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] CNT_QAM16  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] CNT_QAM64  = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] CNT_QAM256 = COUNT_W'(8);

    // one threshold fold: |a| - t
    function automatic opnd_t fold(input opnd_t a, input opnd_t t);
        opnd_t mag;
        begin
            mag = a[OPW-1] ? -a : a;
            return mag - t;
        end
    endfunction

endpackage

### hw/rtl/qam_soft_llr_demapper_core.sv
// max-log gray qam soft demapper core: five-stage pipeline
//
// One word (in_phase, quadrature, noise_scale) is taken on every clock edge
// where start is high; busy is always low. Results come out with done high
// for one cycle, in order, one result per word, and the receiver cannot
// stall them. The five register stages are input capture, threshold folding,
// scale multiply, second-factor multiply (1/sqrt2 or unity), and rounding
// with saturation. The modulation register is written through
// cfg_valid/cfg_ready (always ready) and must only change while no word is
// in flight. Unused llr lanes are zero; codes 5 to 7 act as QPSK.
module qam_soft_llr_demapper_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [qsld_pkg::SAMPLE_W-1:0] in_phase,
    input  logic signed [qsld_pkg::SAMPLE_W-1:0] quadrature,
    input  logic        [qsld_pkg::SCALE_W-1:0]  noise_scale,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [2:0]                    cfg_data,
    output logic                                 done,
    output logic signed [qsld_pkg::LLR_W-1:0]    llr_0,
    output logic signed [qsld_pkg::LLR_W-1:0]    llr_1,
    output logic signed [qsld_pkg::LLR_W-1:0]    llr_2,
    output logic signed [qsld_pkg::LLR_W-1:0]    llr_3,
    output logic signed [qsld_pkg::LLR_W-1:0]    llr_4,
    output logic signed [qsld_pkg::LLR_W-1:0]    llr_5,
    output logic signed [qsld_pkg::LLR_W-1:0]    llr_6,
    output logic signed [qsld_pkg::LLR_W-1:0]    llr_7,
    output logic        [qsld_pkg::COUNT_W-1:0]  valid_count
);

    localparam int N = qsld_pkg::NUM_LANES;

    // configuration register
    qsld_pkg::mod_t modulation_reg;

    // pipeline valid bits
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;

    // stage a: captured word
    logic signed [qsld_pkg::SAMPLE_W-1:0] a_ip_reg, a_qp_reg;
    logic        [qsld_pkg::SCALE_W-1:0]  a_sc_reg;
    qsld_pkg::mod_t                       a_mod_reg;

    // stage b: lane operands
    qsld_pkg::opnd_t                      b_op_reg [N];
    qsld_pkg::opnd_t                      b_op_next [N];
    logic        [qsld_pkg::SCALE_W-1:0]  b_sc_reg;
    logic                                 b_qpsk_reg, b_qpsk_next;
    logic        [qsld_pkg::COUNT_W-1:0]  b_cnt_reg, b_cnt_next;

    // stage c: scaled products
    qsld_pkg::prod_t                      c_prod_reg [N];
    qsld_pkg::prod_t                      c_prod_next [N];
    logic                                 c_qpsk_reg;
    logic        [qsld_pkg::COUNT_W-1:0]  c_cnt_reg;

    // stage d: lanes 0 and 1 carry the second factor
    qsld_pkg::wide_t                      d_wide_reg [2];
    qsld_pkg::wide_t                      d_wide_next [2];
    qsld_pkg::prod_t                      d_prod_reg [N];
    logic        [qsld_pkg::COUNT_W-1:0]  d_cnt_reg;

    // stage e: output lanes
    qsld_pkg::llr_t                       e_llr_reg [N];
    qsld_pkg::llr_t                       e_llr_next [N];
    logic        [qsld_pkg::COUNT_W-1:0]  e_cnt_reg;

    // handshakes
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulation_reg <= qsld_pkg::MOD_QPSK;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                modulation_reg <= qsld_pkg::mod_t'(cfg_data);
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // stage b: threshold folds per axis and lane placement
    always_comb
    begin
        qsld_pkg::opnd_t xi, xq, ni, nq;
        qsld_pkg::opnd_t i1, i2, i3, q1, q2, q3;
        qsld_pkg::opnd_t t1, t2, t3;
        xi = qsld_pkg::opnd_t'(a_ip_reg);
        xq = qsld_pkg::opnd_t'(a_qp_reg);
        ni = -xi;
        nq = -xq;
        t1 = qsld_pkg::TH256_HI;
        t2 = qsld_pkg::TH256_MID;
        t3 = qsld_pkg::TH256_LO;
        case (a_mod_reg)
            qsld_pkg::MOD_QAM16:
            begin
                t1 = qsld_pkg::TH_16;
            end
            qsld_pkg::MOD_QAM64:
            begin
                t1 = qsld_pkg::TH64_HI;
                t2 = qsld_pkg::TH64_LO;
            end
            default:
            begin
                t1 = qsld_pkg::TH256_HI;
            end
        endcase
        i1 = qsld_pkg::fold(xi, t1);
        i2 = qsld_pkg::fold(i1, t2);
        i3 = qsld_pkg::fold(i2, t3);
        q1 = qsld_pkg::fold(xq, t1);
        q2 = qsld_pkg::fold(q1, t2);
        q3 = qsld_pkg::fold(q2, t3);
        for (int i = 0; i < N; i++)
            b_op_next[i] = '0;
        b_qpsk_next = 1'b0;
        case (a_mod_reg)
            qsld_pkg::MOD_BPSK:
            begin
                b_op_next[0] = ni;
                b_cnt_next   = qsld_pkg::CNT_BPSK;
            end
            qsld_pkg::MOD_QAM16:
            begin
                b_op_next[0] = ni;
                b_op_next[1] = i1;
                b_op_next[2] = nq;
                b_op_next[3] = q1;
                b_cnt_next   = qsld_pkg::CNT_QAM16;
            end
            qsld_pkg::MOD_QAM64:
            begin
                b_op_next[0] = ni;
                b_op_next[1] = i1;
                b_op_next[2] = i2;
                b_op_next[3] = nq;
                b_op_next[4] = q1;
                b_op_next[5] = q2;
                b_cnt_next   = qsld_pkg::CNT_QAM64;
            end
            qsld_pkg::MOD_QAM256:
            begin
                b_op_next[0] = ni;
                b_op_next[1] = i1;
                b_op_next[2] = i2;
                b_op_next[3] = i3;
                b_op_next[4] = nq;
                b_op_next[5] = q1;
                b_op_next[6] = q2;
                b_op_next[7] = q3;
                b_cnt_next   = qsld_pkg::CNT_QAM256;
            end
            default:
            begin
                // qpsk and unknown codes
                b_op_next[0] = ni;
                b_op_next[1] = nq;
                b_qpsk_next  = 1'b1;
                b_cnt_next   = qsld_pkg::CNT_QPSK;
            end
        endcase
    end

    // stage c: multiply by noise scale
    always_comb
    begin
        for (int i = 0; i < N; i++)
            c_prod_next[i] = qsld_pkg::prod_t'(b_op_reg[i]) * $signed({1'b0, b_sc_reg});
    end

    // stage d: second factor on lanes 0 and 1
    always_comb
    begin
        qsld_pkg::factor_t f;
        f = c_qpsk_reg ? qsld_pkg::INV_SQRT2_Q16 : qsld_pkg::UNITY_Q16;
        for (int i = 0; i < 2; i++)
            d_wide_next[i] = qsld_pkg::wide_t'(c_prod_reg[i]) * f;
    end

    // stage e: round half up and saturate
    always_comb
    begin
        qsld_pkg::wide_t sum_hi;
        qsld_pkg::prod_t sum_lo;
        logic signed [qsld_pkg::QW-qsld_pkg::SHIFT_HI-1:0] r_hi;
        logic signed [qsld_pkg::PW-qsld_pkg::SHIFT_LO-1:0] r_lo;
        for (int i = 0; i < N; i++)
        begin
            if (i < 2)
            begin
                sum_hi = d_wide_reg[i[0]] + (qsld_pkg::wide_t'(1) <<< (qsld_pkg::SHIFT_HI - 1));
                r_hi   = sum_hi[qsld_pkg::QW-1:qsld_pkg::SHIFT_HI];
                if (r_hi > $signed({{(qsld_pkg::QW-qsld_pkg::SHIFT_HI-qsld_pkg::LLR_W+1){1'b0}},
                                    {(qsld_pkg::LLR_W-1){1'b1}}}))
                    e_llr_next[i] = {1'b0, {(qsld_pkg::LLR_W-1){1'b1}}};
                else if (r_hi < $signed({{(qsld_pkg::QW-qsld_pkg::SHIFT_HI-qsld_pkg::LLR_W+1){1'b1}},
                                         {(qsld_pkg::LLR_W-1){1'b0}}}))
                    e_llr_next[i] = {1'b1, {(qsld_pkg::LLR_W-1){1'b0}}};
                else
                    e_llr_next[i] = r_hi[qsld_pkg::LLR_W-1:0];
            end
            else
            begin
                sum_lo = d_prod_reg[i] + (qsld_pkg::prod_t'(1) <<< (qsld_pkg::SHIFT_LO - 1));
                r_lo   = sum_lo[qsld_pkg::PW-1:qsld_pkg::SHIFT_LO];
                if (r_lo > $signed({{(qsld_pkg::PW-qsld_pkg::SHIFT_LO-qsld_pkg::LLR_W+1){1'b0}},
                                    {(qsld_pkg::LLR_W-1){1'b1}}}))
                    e_llr_next[i] = {1'b0, {(qsld_pkg::LLR_W-1){1'b1}}};
                else if (r_lo < $signed({{(qsld_pkg::PW-qsld_pkg::SHIFT_LO-qsld_pkg::LLR_W+1){1'b1}},
                                         {(qsld_pkg::LLR_W-1){1'b0}}}))
                    e_llr_next[i] = {1'b1, {(qsld_pkg::LLR_W-1){1'b0}}};
                else
                    e_llr_next[i] = r_lo[qsld_pkg::LLR_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_ip_reg   <= in_phase;
        a_qp_reg   <= quadrature;
        a_sc_reg   <= noise_scale;
        a_mod_reg  <= modulation_reg;
        b_op_reg   <= b_op_next;
        b_sc_reg   <= a_sc_reg;
        b_qpsk_reg <= b_qpsk_next;
        b_cnt_reg  <= b_cnt_next;
        c_prod_reg <= c_prod_next;
        c_qpsk_reg <= b_qpsk_reg;
        c_cnt_reg  <= b_cnt_reg;
        d_wide_reg <= d_wide_next;
        d_prod_reg <= c_prod_reg;
        d_cnt_reg  <= c_cnt_reg;
        e_llr_reg  <= e_llr_next;
        e_cnt_reg  <= d_cnt_reg;
    end

    // result ports
    assign done        = e_valid_reg;
    assign llr_0       = e_llr_reg[0];
    assign llr_1       = e_llr_reg[1];
    assign llr_2       = e_llr_reg[2];
    assign llr_3       = e_llr_reg[3];
    assign llr_4       = e_llr_reg[4];
    assign llr_5       = e_llr_reg[5];
    assign llr_6       = e_llr_reg[6];
    assign llr_7       = e_llr_reg[7];
    assign valid_count = e_cnt_reg;

endmodule

### hw/rtl/qsld_checker.sv
// port-level checker for the demapper core and its bind
module qsld_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic signed [qsld_pkg::LLR_W-1:0]    llr_1,
    input logic signed [qsld_pkg::LLR_W-1:0]    llr_2,
    input logic signed [qsld_pkg::LLR_W-1:0]    llr_3,
    input logic signed [qsld_pkg::LLR_W-1:0]    llr_4,
    input logic signed [qsld_pkg::LLR_W-1:0]    llr_5,
    input logic signed [qsld_pkg::LLR_W-1:0]    llr_6,
    input logic signed [qsld_pkg::LLR_W-1:0]    llr_7,
    input logic        [qsld_pkg::COUNT_W-1:0]  valid_count
);

    // every accepted word gives a result after the fixed latency
    a_word_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(qsld_pkg::LATENCY) done)
        else $error("accepted word produced no result");

    // no result without a word accepted at the matching edge
    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, qsld_pkg::LATENCY))
        else $error("result without an accepted word");

    // lane count is one of the legal values
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (valid_count == qsld_pkg::CNT_BPSK || valid_count == qsld_pkg::CNT_QPSK ||
                  valid_count == qsld_pkg::CNT_QAM16 || valid_count == qsld_pkg::CNT_QAM64 ||
                  valid_count == qsld_pkg::CNT_QAM256))
        else $error("illegal valid_count");

    // lanes above the count are zero for bpsk and qpsk
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (valid_count == qsld_pkg::CNT_BPSK || valid_count == qsld_pkg::CNT_QPSK))
        |-> (llr_2 == '0 && llr_3 == '0 && llr_4 == '0 && llr_5 == '0 &&
             llr_6 == '0 && llr_7 == '0 &&
             (valid_count == qsld_pkg::CNT_QPSK || llr_1 == '0)))
        else $error("unused llr lane not zero");

endmodule

bind qam_soft_llr_demapper_core qsld_checker u_qsld_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .llr_1       (llr_1),
    .llr_2       (llr_2),
    .llr_3       (llr_3),
    .llr_4       (llr_4),
    .llr_5       (llr_5),
    .llr_6       (llr_6),
    .llr_7       (llr_7),
    .valid_count (valid_count)
);
